### design/lirs_pkg.sv
// shared constants and types for the linear interpolation resampler
package lirs_pkg;

  localparam int FRAC_BITS = 16;
  localparam int SAMPLE_W  = 16;
  localparam int STEP_W    = 19;
  localparam int MAX_OUT   = 6;

  // one guard bit on the difference of two samples
  localparam int DIFF_W  = SAMPLE_W + 1;
  localparam int PROD_W  = DIFF_W + FRAC_BITS;
  // phase below one plus the largest step, with a bit to spare
  localparam int PHASE_W = ((FRAC_BITS + 1 > STEP_W) ? FRAC_BITS + 1 : STEP_W) + 1;
  localparam int CNT_W   = $clog2(MAX_OUT + 1);

  localparam logic [PHASE_W-1:0] ONE_PHASE  = PHASE_W'(1) << FRAC_BITS;
  localparam logic [STEP_W-1:0]  STEP_RESET = STEP_W'(43691);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_CALC = 3'b010,
    S_OUT  = 3'b100
  } state_e;

endpackage

### design/linear_interp_resampler_unit.sv
// linear interpolation sample-rate converter, top level
//
// input channel: in_valid_i with sample_in_i and restart_i, held off by in_stall_o.
// output channel: out_valid_o with sample_out_o and last_of_run_o, held off by
// out_stall_i. a transfer happens on a rising edge with valid high and stall low.
// ratio_step_i is loaded when ratio_step_we_i is high; write it only while the
// block is idle; the block itself does not enforce this. one input is worked
// on at a time; for an input that gives outputs, in_stall_o is high from the
// cycle after its transfer in until its last output has been transferred. an
// input that only primes the stored sample, or that is skipped because the
// phase is still at or above one, gives no output. otherwise each output goes
// through the one shared multiplier: the calc state forms |cur - prev| * phase
// and the output state presents the result. an input gives up to 6 outputs,
// and the next input is taken on the cycle after the last output transfer.
// reset empties the stored sample, clears the phase and loads the default step
// (16000 over 24000 in q16). a stalling receiver simply holds the sequencer in
// the output state with the result steady.
module linear_interp_resampler_unit
  import lirs_pkg::*;
(
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic signed [SAMPLE_W-1:0] sample_in_i,
  input  logic                       restart_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic signed [SAMPLE_W-1:0] sample_out_o,
  output logic                       last_of_run_o,
  input  logic                       ratio_step_we_i,
  input  logic [STEP_W-1:0]          ratio_step_i
);

  state_e state_q, state_d;

  logic [STEP_W-1:0]          ratio_step_q;
  logic signed [SAMPLE_W-1:0] prev_q, prev_d;
  logic signed [SAMPLE_W-1:0] cur_q, cur_d;
  logic                       have_q, have_d;
  logic [PHASE_W-1:0]         phase_q, phase_d;
  logic [CNT_W-1:0]           cnt_q, cnt_d;
  logic [DIFF_W-1:0]          part_q, part_d;
  logic                       neg_q, neg_d;
  logic                       last_q, last_d;

  // datapath: difference, magnitude and the shared multiplier
  logic signed [DIFF_W-1:0] diff;
  logic [DIFF_W-1:0]        mag;
  logic [PROD_W-1:0]        prod;
  logic [PHASE_W-1:0]       phase_sum;
  logic [PHASE_W-1:0]       phase_in;
  logic                     have_in;
  logic signed [DIFF_W-1:0] part_s;
  logic signed [DIFF_W-1:0] out_sum;

  assign diff      = DIFF_W'(cur_q) - DIFF_W'(prev_q);
  assign mag       = diff[DIFF_W-1] ? DIFF_W'(-diff) : DIFF_W'(diff);
  assign prod      = PROD_W'(mag) * PROD_W'(phase_q[FRAC_BITS-1:0]);
  assign phase_sum = phase_q + PHASE_W'(ratio_step_q);

  // restart drops the stored sample and phase before the new sample is used
  assign phase_in = restart_i ? '0 : phase_q;
  assign have_in  = have_q & ~restart_i;

  // interpolated sample, truncated toward zero on the magnitude
  assign part_s  = neg_q ? -$signed(part_q) : $signed(part_q);
  assign out_sum = DIFF_W'(prev_q) + part_s;

  assign in_stall_o    = (state_q != S_IDLE);
  assign out_valid_o   = (state_q == S_OUT);
  assign sample_out_o  = out_sum[SAMPLE_W-1:0];
  assign last_of_run_o = last_q;

  always_comb begin
    state_d = state_q;
    prev_d  = prev_q;
    cur_d   = cur_q;
    have_d  = have_q;
    phase_d = phase_q;
    cnt_d   = cnt_q;
    part_d  = part_q;
    neg_d   = neg_q;
    last_d  = last_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cur_d = sample_in_i;
          if (!have_in) begin
            // priming only
            prev_d  = sample_in_i;
            have_d  = 1'b1;
            phase_d = phase_in;
          end else if (phase_in >= ONE_PHASE) begin
            // sample skipped, phase steps down by one
            prev_d  = sample_in_i;
            phase_d = phase_in - ONE_PHASE;
          end else begin
            phase_d = phase_in;
            cnt_d   = '0;
            state_d = S_CALC;
          end
        end
      end
      S_CALC: begin
        part_d  = prod[PROD_W-1:FRAC_BITS];
        neg_d   = diff[DIFF_W-1];
        phase_d = phase_sum;
        cnt_d   = cnt_q + CNT_W'(1);
        last_d  = (phase_sum >= ONE_PHASE) || (cnt_q == CNT_W'(MAX_OUT - 1));
        state_d = S_OUT;
      end
      S_OUT: begin
        if (!out_stall_i) begin
          if (last_q) begin
            // end of run: wrap the phase, saturating at zero on a short run
            phase_d = (phase_q >= ONE_PHASE) ? phase_q - ONE_PHASE : '0;
            prev_d  = cur_q;
            state_d = S_IDLE;
          end else begin
            state_d = S_CALC;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      ratio_step_q <= STEP_RESET;
      prev_q       <= '0;
      have_q       <= 1'b0;
      phase_q      <= '0;
      cnt_q        <= '0;
      last_q       <= 1'b0;
    end else begin
      state_q <= state_d;
      if (ratio_step_we_i) begin
        ratio_step_q <= ratio_step_i;
      end
      prev_q  <= prev_d;
      have_q  <= have_d;
      phase_q <= phase_d;
      cnt_q   <= cnt_d;
      last_q  <= last_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    cur_q  <= cur_d;
    part_q <= part_d;
    neg_q  <= neg_d;
  end

  // an output is only ever shown while the input side is held off
  a_out_blocks_in : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o)
    else $error("output presented while input side open");

  // every multiply cycle is followed by a presented result
  a_calc_then_out : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CALC) |=> out_valid_o)
    else $error("multiply cycle not followed by output");

  // the multiplier only sees a phase below one
  a_calc_phase : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CALC) |-> (phase_q < ONE_PHASE))
    else $error("phase at or above one in multiply cycle");

  // output count per input stays within one to six, and the sixth is last
  a_out_count : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (cnt_q != '0) && (cnt_q <= CNT_W'(MAX_OUT))
                    && ((cnt_q != CNT_W'(MAX_OUT)) || last_of_run_o))
    else $error("output count out of range");

endmodule

### test/testbench.sv
`timescale 1ns / 1ps
// self-checking testbench for the linear interpolation resampler
module testbench;
  import lirs_pkg::*;

  localparam int CLK_PERIOD  = 20;
  // far above the slowest correct run: every item with six outputs, every output
  // behind the longest random stall, every input behind the longest random gap
  localparam int CYCLE_LIMIT = 400000;
  localparam int LONG_HOLD   = 300;
  // a priming or skipped input has nothing to show for it
  localparam int DRAIN_WAIT  = 6;
  localparam int PHASE_ITEMS = 50;
  localparam int NUM_PHASES  = 9;

  // ways of making input samples
  typedef enum int {
    SRC_NOISE,
    SRC_SMOOTH,
    SRC_EXTREME
  } sample_src_e;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       last;
  } resampled_t;

  // keeps its own copy of stored sample, phase and step, and the outputs
  // still owed by the block in arrival order
  class resampler_scoreboard;
    logic signed [SAMPLE_W-1:0] held_sample;
    bit                         have_held;
    longint unsigned            phase;
    logic [STEP_W-1:0]          step;
    resampled_t                 owed_outputs[$];
    int                         errors;

    function new();
      held_sample = '0;
      have_held   = 1'b0;
      phase       = 0;
      step        = STEP_RESET;
      errors      = 0;
    endfunction

    function void load_step(logic [STEP_W-1:0] value);
      step = value;
    endfunction

    function int pending();
      return owed_outputs.size();
    endfunction

    task report(string msg);
      $display("[%0t] mismatch: %s", $time, msg);
      errors++;
    endtask

    // prev + (cur - prev) * frac, the product truncated toward zero
    function logic signed [SAMPLE_W-1:0] blend(logic signed [SAMPLE_W-1:0] a,
                                               logic signed [SAMPLE_W-1:0] b,
                                               longint unsigned frac);
      int              diff;
      longint unsigned mag;
      longint          part;
      diff = int'(b) - int'(a);
      mag  = (diff < 0) ? -diff : diff;
      part = longint'((mag * frac) >> FRAC_BITS);
      if (diff < 0) part = -part;
      return SAMPLE_W'(longint'(a) + part);
    endfunction

    task note_input(logic signed [SAMPLE_W-1:0] cur, logic restart);
      longint unsigned one;
      int              n;
      resampled_t      r;
      one = 64'd1 << FRAC_BITS;
      n   = 0;
      if (restart) begin
        have_held = 1'b0;
        phase     = 0;
      end
      if (!have_held) begin
        held_sample = cur;
        have_held   = 1'b1;
        return;
      end
      while (phase < one && n < MAX_OUT) begin
        r.sample = blend(held_sample, cur, phase);
        r.last   = (phase + step >= one) || (n == MAX_OUT - 1);
        owed_outputs.push_back(r);
        n++;
        phase += step;
      end
      if (phase >= one) phase -= one;
      else phase = 0;
      held_sample = cur;
    endtask

    task check_result(logic signed [SAMPLE_W-1:0] sample, logic last);
      resampled_t want;
      if (owed_outputs.size() == 0) begin
        report($sformatf("output %0d last %0b with nothing owed", sample, last));
        return;
      end
      want = owed_outputs.pop_front();
      if (sample !== want.sample)
        report($sformatf("sample_out %0d, wanted %0d", sample, want.sample));
      if (last !== want.last)
        report($sformatf("last_of_run %0b, wanted %0b", last, want.last));
    endtask
  endclass

  logic                       clk_i;
  logic                       rst_ni;
  logic                       in_valid_i;
  logic                       in_stall_o;
  logic signed [SAMPLE_W-1:0] sample_in_i;
  logic                       restart_i;
  logic                       out_valid_o;
  logic                       out_stall_i;
  logic signed [SAMPLE_W-1:0] sample_out_o;
  logic                       last_of_run_o;
  logic                       ratio_step_we_i;
  logic [STEP_W-1:0]          ratio_step_i;

  resampler_scoreboard resample_check = new();

  bit sender_idles;
  bit receiver_idles;
  bit hold_request;
  int cycle_count = 0;

  linear_interp_resampler_unit u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .sample_in_i     (sample_in_i),
    .restart_i       (restart_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .sample_out_o    (sample_out_o),
    .last_of_run_o   (last_of_run_o),
    .ratio_step_we_i (ratio_step_we_i),
    .ratio_step_i    (ratio_step_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #(CLK_PERIOD / 2) clk_i = ~clk_i;
  end

  // everything is sampled at the edge, before any of this edge's updates land;
  // an output transfer belongs to an earlier input, so it is checked first
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) resample_check.check_result(sample_out_o, last_of_run_o);
      if (in_valid_i && !in_stall_o) resample_check.note_input(sample_in_i, restart_i);
      if (ratio_step_we_i) resample_check.load_step(ratio_step_i);
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("testbench: done, errors");
      $finish;
    end
  end

  // receiver: random stall bursts, one long hold-off on request, none at the end
  initial begin
    @(posedge clk_i);
    forever begin
      if (hold_request) begin
        out_stall_i <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk_i);
        hold_request = 1'b0;
      end else if (receiver_idles && $urandom_range(0, 3) == 0) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 8)) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      @(posedge clk_i);
    end
  end

  // offer one sample and hold it until the block takes it, then maybe go quiet
  task automatic push_sample(input logic signed [SAMPLE_W-1:0] s, input logic r);
    in_valid_i  <= 1'b1;
    sample_in_i <= s;
    restart_i   <= r;
    do @(posedge clk_i); while (in_stall_o);
    if (sender_idles && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
    end
  endtask

  // stop sending until every owed output has come and the block is quiet
  task automatic settle();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (resample_check.pending() != 0);
    repeat (DRAIN_WAIT) @(posedge clk_i);
  endtask

  task automatic write_step(input logic [STEP_W-1:0] value);
    ratio_step_we_i <= 1'b1;
    ratio_step_i    <= value;
    @(posedge clk_i);
    ratio_step_we_i <= 1'b0;
  endtask

  function automatic logic signed [SAMPLE_W-1:0] make_sample(
      input sample_src_e src, input logic signed [SAMPLE_W-1:0] last);
    int v;
    case (src)
      SRC_SMOOTH: begin
        v = int'(last) + int'($urandom_range(0, 4000)) - 2000;
        if (v > 32767) v = 32767;
        if (v < -32768) v = -32768;
        return SAMPLE_W'(v);
      end
      SRC_EXTREME: begin
        case ($urandom_range(0, 3))
          0: return 16'sh8000;
          1: return 16'sh7fff;
          2: return 16'sh0000;
          default: return 16'shffff;
        endcase
      end
      default: return SAMPLE_W'($urandom);
    endcase
  endfunction

  // step for each random phase: reset value, both ends of the useful range,
  // exact one, a fully random 19-bit value and values in between
  function automatic logic [STEP_W-1:0] phase_step(input int p);
    case (p)
      0: return STEP_RESET;
      1: return STEP_W'($urandom_range(10923, 65535));
      2: return STEP_W'($urandom_range(65536, 393216));
      3: return STEP_W'(10923);
      4: return STEP_W'($urandom);
      5: return STEP_W'(393216);
      6: return STEP_W'(65536);
      7: return STEP_W'(32768);
      default: return STEP_RESET;
    endcase
  endfunction

  initial begin
    logic signed [SAMPLE_W-1:0] s;
    sample_src_e                src;

    rst_ni          <= 1'b0;
    in_valid_i      <= 1'b0;
    sample_in_i     <= '0;
    restart_i       <= 1'b0;
    out_stall_i     <= 1'b0;
    ratio_step_we_i <= 1'b0;
    ratio_step_i    <= '0;
    sender_idles    = 1'b1;
    receiver_idles  = 1'b1;
    hold_request    = 1'b0;
    s               = '0;

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // default step straight out of reset
    push_sample(16'sh8000, 1'b1);  // restart on an empty block only primes
    push_sample(16'sh7fff, 1'b0);  // widest rising difference
    push_sample(16'sh8000, 1'b0);  // widest falling difference
    push_sample(16'sh0000, 1'b0);
    push_sample(16'shffff, 1'b0);
    push_sample(16'sh7fff, 1'b1);  // restart mid-stream primes again
    push_sample(16'sh7fff, 1'b0);
    push_sample(16'sh8000, 1'b0);
    settle();

    // zero step: six outputs each time, then the phase falls back to zero
    write_step('0);
    push_sample(16'sh0064, 1'b0);
    push_sample(16'sh8000, 1'b0);
    push_sample(16'sh7fff, 1'b0);
    settle();

    // smallest nonzero step
    write_step(STEP_W'(1));
    push_sample(16'sh8000, 1'b0);
    push_sample(16'sh7fff, 1'b0);
    settle();

    // large step: inputs skipped while the phase stays at or above one
    write_step(STEP_W'(393216));
    push_sample(16'sh1234, 1'b0);
    push_sample(16'sh8000, 1'b0);
    push_sample(16'sh7fff, 1'b0);
    push_sample(16'shedcb, 1'b0);
    push_sample(16'sh0001, 1'b0);
    settle();

    // all-ones step register
    write_step('1);
    push_sample(16'sh7fff, 1'b0);
    push_sample(16'sh8000, 1'b0);
    push_sample(16'sh4000, 1'b0);
    settle();

    // lowest useful step, exactly six outputs ended by the phase
    write_step(STEP_W'(10923));
    push_sample(16'sh8000, 1'b0);
    push_sample(16'sh7fff, 1'b0);
    push_sample(16'sh0000, 1'b0);
    settle();

    // random phases, each with its own step and style of samples
    for (int p = 0; p < NUM_PHASES; p++) begin
      if (p == NUM_PHASES - 1) begin
        sender_idles   = 1'b0;
        receiver_idles = 1'b0;
      end
      write_step(phase_step(p));
      src = sample_src_e'(p % 3);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        // fill the block behind a long receiver hold-off
        if (p == 1 && i == 5) hold_request = 1'b1;
        // mid-phase pause until every owed output is out
        if (p == 4 && i == PHASE_ITEMS / 2) settle();
        s = make_sample(src, s);
        push_sample(s, $urandom_range(0, 19) == 0);
      end
      settle();
    end

    if (resample_check.errors == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule
